/* rtl/nt_pkg.sv */
`default_nettype none

package nt_pkg;

    // Field widths fixed by the item format
    localparam int NODE_W    = 64;
    localparam int SCORE_W   = 7;
    localparam int CAPS_W    = 8;
    localparam int DELTA_W   = 8;
    localparam int INDEX_W   = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    // Input beat layout, lowest bit first
    localparam int IN_ID_LO    = 0;
    localparam int IN_SCORE_LO = IN_ID_LO + NODE_W;
    localparam int IN_CAPS_LO  = IN_SCORE_LO + SCORE_W;
    localparam int IN_MIN_LO   = IN_CAPS_LO + CAPS_W;
    localparam int IN_REQ_LO   = IN_MIN_LO + SCORE_W;
    localparam int IN_DELTA_LO = IN_REQ_LO + CAPS_W;
    localparam int IN_BITS     = IN_DELTA_LO + DELTA_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output beat layout, lowest bit first
    localparam int OUT_BITS  = STATUS_W + 1 + SCORE_W + INDEX_W + NODE_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Defaults for the top level parameters
    localparam int TABLE_DEPTH_DEF    = 16;
    localparam int ID_BYTES_DEF       = 8;
    localparam int MAX_CANDIDATES_DEF = 256;

    // Score ceiling applied by update
    localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CHECK  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_ROUTE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NO_QUAL   = 2'd3
    } status_t;

    // One candidate event into the run tracker
    typedef struct packed {
        logic               fire;   // event this cycle
        logic               step;   // candidate is counted
        logic               cand;   // found, meets minimum and caps
        logic               last;   // closes the run
        logic [SCORE_W-1:0] score;  // candidate score
    } run_ev_t;

    // Run tracker view, including the event of this cycle
    typedef struct packed {
        logic               found;
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] index;
    } run_res_t;

    // One result beat
    typedef struct packed {
        op_t                op;
        status_t            status;
        logic               trusted;
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] index;
        logic [NODE_W-1:0]  id;
    } result_t;

endpackage

`default_nettype wire

/* rtl/nt_ram.sv */
`default_nettype none

module nt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/nt_run.sv */
`default_nettype none

module nt_run #(
    parameter int ID_W           = 64,
    parameter int MAX_CANDIDATES = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nt_pkg::run_ev_t  ev,
    input  wire logic [ID_W-1:0]  ev_id,
    output logic                  run_full,
    output nt_pkg::run_res_t      res,
    output logic      [ID_W-1:0]  res_id
);

    import nt_pkg::*;

    localparam int POS_W  = $clog2(MAX_CANDIDATES + 1);
    localparam int PIDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

    logic               has_reg, has_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [PIDX_W-1:0]  best_pos_reg, best_pos_next;
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic               take;

    assign run_full = (pos_reg == POS_W'(MAX_CANDIDATES));

    // New best only on a strictly higher score
    assign take = ev.fire && ev.step && ev.cand &&
                  (!has_reg || (ev.score > best_score_reg));

    // View after this cycle's candidate
    assign best_score_next = take ? ev.score : best_score_reg;
    assign best_pos_next   = take ? pos_reg[PIDX_W-1:0] : best_pos_reg;
    assign best_id_next    = take ? ev_id : best_id_reg;

    always_comb
    begin
        res.found = has_reg || take;
        res.score = best_score_next;
        res.index = INDEX_W'(best_pos_next);
        res_id    = best_id_next;
    end

    // Run bookkeeping; the closing beat returns to the empty run
    always_comb
    begin
        has_next = has_reg || take;
        pos_next = pos_reg;
        if (ev.fire && ev.step)
        begin
            pos_next = POS_W'(pos_reg + 1'b1);
        end
        if (ev.fire && ev.last)
        begin
            has_next = 1'b0;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            has_reg <= has_next;
            pos_reg <= pos_next;
        end
    end

    // Best candidate payload, qualified by has_reg
    always_ff @(posedge clk)
    begin
        best_score_reg <= best_score_next;
        best_pos_reg   <= best_pos_next;
        best_id_reg    <= best_id_next;
    end

endmodule

`default_nettype wire

/* rtl/node_trust_table.sv */
`default_nettype none

// Channel  Dir  Beat payload
// s_*      in   tuser op; tlast last_candidate; tdata node_id, score, caps,
//               min_score, required_caps, score_delta
// m_*      out  tuser done_op; tdata status, trusted, entry_score,
//               selected_index, selected_id
//
// Add goes from idle straight to the response state. Check, update and route
// scan the table from entry 0, one RAM read per cycle, with the compare on the
// read data in the cycle after; the scan ends at the first match or at the fill.
// The entry RAM has a single read port. A candidate past the run limit is not
// scanned, and goes to the response state only when it closes the run. Update
// writes back in the match cycle. Reset empties the table and the route run; no
// clearing pass. Input is taken in idle only; a result still waiting in the
// output register holds the next result in the response state, and the
// intake stalls until it drains.

module node_trust_table #(
    parameter int TABLE_DEPTH    = nt_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BYTES       = nt_pkg::ID_BYTES_DEF,
    parameter int MAX_CANDIDATES = nt_pkg::MAX_CANDIDATES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // node_id, score, caps, min_score, required_caps, score_delta, pad
    input  wire logic [nt_pkg::S_TDATA_W-1:0] s_tdata,
    // op
    input  wire logic [nt_pkg::OP_W-1:0]      s_tuser,
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // status, trusted, entry_score, selected_index, selected_id, pad
    output logic      [nt_pkg::M_TDATA_W-1:0] m_tdata,
    // done_op
    output logic      [nt_pkg::OP_W-1:0]      m_tuser
);

    import nt_pkg::*;

    localparam int ID_W  = 8 * ID_BYTES;
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = ID_W + CAPS_W + SCORE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pidx_reg, pidx_next;

    op_t                op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SCORE_W-1:0] min_reg;
    logic [CAPS_W-1:0]  req_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic               last_reg;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;

    // Input beat fields
    op_t                in_op;
    logic [ID_W-1:0]    in_id;
    logic [SCORE_W-1:0] in_score;
    logic [CAPS_W-1:0]  in_caps;
    logic               accept;
    logic               full;

    // Entry RAM
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [ENT_W-1:0]   ram_wdata, ram_rdata;

    // Scan view of the entry read last cycle
    logic [ID_W-1:0]    ent_id;
    logic [CAPS_W-1:0]  ent_caps;
    logic [SCORE_W-1:0] ent_score;
    logic               hit, more, scan_done;
    logic signed [8:0]  upd_sum;
    logic [SCORE_W-1:0] upd_score;

    // Route run tracker
    run_ev_t            ev;
    logic [ID_W-1:0]    ev_id;
    logic               run_full;
    run_res_t           run_res;
    logic [ID_W-1:0]    run_id;
    result_t            route_res;
    logic               res_load;

    assign in_op    = op_t'(s_tuser);
    assign in_id    = s_tdata[IN_ID_LO +: ID_W];
    assign in_score = s_tdata[IN_SCORE_LO +: SCORE_W];
    assign in_caps  = s_tdata[IN_CAPS_LO +: CAPS_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(TABLE_DEPTH));

    assign ent_id    = ram_rdata[ENT_W-1 -: ID_W];
    assign ent_caps  = ram_rdata[SCORE_W +: CAPS_W];
    assign ent_score = ram_rdata[SCORE_W-1:0];

    // Scan: compare entry read last cycle, issue next read unless matched or past the fill
    assign hit       = (state_reg == S_SCAN) && pend_reg && (ent_id == id_reg);
    assign more      = (idx_reg < count_reg);
    assign scan_done = (state_reg == S_SCAN) && (hit || !more);
    assign ram_re    = (state_reg == S_SCAN) && !hit && more;

    // Update arithmetic with clamp to 0..100
    assign upd_sum = $signed({2'b00, ent_score}) + $signed({delta_reg[DELTA_W-1], delta_reg});

    always_comb
    begin
        if (upd_sum < 9'sd0)
        begin
            upd_score = '0;
        end
        else if (upd_sum > $signed({2'b00, SCORE_MAX}))
        begin
            upd_score = SCORE_MAX;
        end
        else
        begin
            upd_score = upd_sum[SCORE_W-1:0];
        end
    end

    // RAM write: append on add, write back on update match
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pidx_reg;
        ram_wdata = {ent_id, ent_caps, upd_score};
        if (accept && (in_op == OP_ADD) && !full)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = {in_id, in_caps, in_score};
        end
        else if (hit && (op_reg == OP_UPDATE))
        begin
            ram_we = 1'b1;
        end
    end

    nt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Candidate event: at scan end, or at once when the run is past its limit
    always_comb
    begin
        ev       = '0;
        ev_id    = id_reg;
        ev.score = ent_score;
        if (accept && (in_op == OP_ROUTE) && run_full)
        begin
            ev.fire = 1'b1;
            ev.last = s_tlast;
        end
        else if (scan_done && (op_reg == OP_ROUTE))
        begin
            ev.fire = 1'b1;
            ev.step = 1'b1;
            ev.last = last_reg;
            ev.cand = hit && (ent_score >= min_reg) &&
                      ((req_reg == '0) || ((ent_caps & req_reg) != '0));
        end
    end

    nt_run #(
        .ID_W           (ID_W),
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_run (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .ev_id    (ev_id),
        .run_full (run_full),
        .res      (run_res),
        .res_id   (run_id)
    );

    // Route run result
    always_comb
    begin
        route_res    = '0;
        route_res.op = OP_ROUTE;
        if (run_res.found)
        begin
            route_res.status = ST_OK;
            route_res.score  = run_res.score;
            route_res.index  = run_res.index;
            route_res.id     = NODE_W'(run_id);
        end
        else
        begin
            route_res.status = ST_NO_QUAL;
        end
    end

    // Sequencer next state and result build
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        res_next   = res_reg;
        res_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idx_next  = '0;
                pend_next = 1'b0;
                if (accept)
                begin
                    case (in_op)
                        OP_ADD:
                        begin
                            res_load       = 1'b1;
                            res_next       = '0;
                            res_next.op    = OP_ADD;
                            state_next     = S_RESP;
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                res_next.status = ST_OK;
                                res_next.score  = in_score;
                                count_next      = CW'(count_reg + 1'b1);
                            end
                        end
                        OP_ROUTE:
                        begin
                            if (!run_full)
                            begin
                                state_next = S_SCAN;
                            end
                            else if (s_tlast)
                            begin
                                res_load   = 1'b1;
                                res_next   = route_res;
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                pend_next = ram_re;
                if (ram_re)
                begin
                    idx_next  = CW'(idx_reg + 1'b1);
                    pidx_next = idx_reg[AW-1:0];
                end
                if (scan_done)
                begin
                    res_next    = '0;
                    res_next.op = op_reg;
                    state_next  = S_RESP;
                    res_load    = 1'b1;
                    case (op_reg)
                        OP_CHECK:
                        begin
                            if (hit)
                            begin
                                res_next.score   = ent_score;
                                res_next.trusted = (ent_score >= min_reg);
                            end
                            else
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (hit)
                            begin
                                res_next.score = upd_score;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            res_next = route_res;
                            if (!last_reg)
                            begin
                                res_load   = 1'b0;
                                state_next = S_IDLE;
                            end
                        end
                    endcase
                    if (!res_load)
                    begin
                        res_next = res_reg;
                    end
                end
            end
            S_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register load and drain
    always_comb
    begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == S_RESP) && (!m_valid_reg || m_tready))
        begin
            m_valid_next = 1'b1;
            out_next     = res_reg;
        end
    end

    // Control state and registered valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            id_reg    <= in_id;
            min_reg   <= s_tdata[IN_MIN_LO +: SCORE_W];
            req_reg   <= s_tdata[IN_REQ_LO +: CAPS_W];
            delta_reg <= s_tdata[IN_DELTA_LO +: DELTA_W];
            last_reg  <= s_tlast;
        end
        pidx_reg <= pidx_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.op;
    assign m_tdata  = M_TDATA_W'({out_reg.id, out_reg.index, out_reg.score,
                                  out_reg.trusted, out_reg.status});

`ifndef SYNTHESIS
    // Fill never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

    // A match is always on a filled entry
    assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (CW'(pidx_reg) < count_reg))
    else $error("scan match outside filled entries");

    // An add with room grows the fill by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_ADD) && !full) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
    else $error("add did not advance entry count");

    // Never a scan read of the entry that a write is issued to
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == idx_reg[AW-1:0])))
    else $error("read and write to one entry in a cycle");
`endif

endmodule

`default_nettype wire
